### hdl/bpf_pkg.sv
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types, codes and sizes of the bezier path flattener.
// ----------------------------------------------------------------------------
package bpf_pkg;

  // subdivision depth limit and derived sizes
  localparam int MAX_LEVEL = 5;
  localparam int LW        = $clog2(MAX_LEVEL + 1);
  localparam int SW        = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
  localparam int MEM_W     = LW + 8 * 32;

  // flatness tolerance used when the register holds zero
  localparam logic [31:0] TOL_DEFAULT = 32'h0000_8000;

  // multiplier: 68-bit magnitudes, 16-bit digits
  localparam int MUL_STEPS = 5;

  // segment codes on the input side
  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_CURVE = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  // segment codes on the output side
  localparam logic [1:0] K_MOVE  = 2'd0;
  localparam logic [1:0] K_LINE  = 2'd1;
  localparam logic [1:0] K_CLOSE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_TEST, S_NEAR1, S_NEAR2, S_SPLIT, S_EMIT, S_POP
  } top_state_t;

  typedef enum logic [3:0] {
    N_IDLE, N_DOT1, N_DOT2, N_DCHK, N_LEN1, N_LEN2, N_LCMP,
    N_CR1, N_CR2, N_CSQ, N_TL, N_SQ1, N_SQ2, N_DCMP
  } near_state_t;

  // status back from the chord distance unit
  typedef struct packed {
    logic done;
    logic near;
  } near_res_t;

  // floor of the average, exact over 33 bits
  function automatic logic signed [31:0] mid(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

endpackage

### hdl/bpf_near.sv
// ----------------------------------------------------------------------------
// bpf_near
// Tests whether a control point lies within tolerance of a chord, exactly,
// with one shared 68x16 multiplier stepped over 16-bit digits.
// ----------------------------------------------------------------------------
module bpf_near (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  px,
  input  logic signed [31:0]  py,
  input  logic signed [31:0]  ax,
  input  logic signed [31:0]  ay,
  input  logic signed [31:0]  bx,
  input  logic signed [31:0]  by,
  input  logic        [63:0]  tol2,
  output bpf_pkg::near_res_t  res
);
  import bpf_pkg::*;

  near_state_t nstate, nstate_next;

  logic signed [32:0]  ux, uy, dx, dy, vx, vy;
  logic                wsel;
  logic signed [135:0] t, dot, len;

  logic                issued, mrun, mdone, mneg;
  logic [2:0]          mcnt;
  logic [67:0]         ma, mb;
  logic [147:0]        acc;
  logic [83:0]         digit_prod;
  logic signed [135:0] mres;
  logic signed [67:0]  op_a, op_b;
  logic                mul_state, load, take;
  logic                fin, fin_near;

  function automatic logic [67:0] mag68(input logic signed [67:0] v);
    return v[67] ? (~v + 68'd1) : v;
  endfunction

  // product of the last multiply with its sign applied
  assign mres = mneg ? -$signed(acc[135:0]) : $signed(acc[135:0]);
  assign digit_prod = ma * mb[15:0];

  // operand selection per step
  always_comb begin
    op_a      = '0;
    op_b      = '0;
    mul_state = 1'b1;
    unique case (nstate)
      N_DOT1: begin op_a = 68'(ux); op_b = 68'(dx); end
      N_DOT2: begin op_a = 68'(uy); op_b = 68'(dy); end
      N_LEN1: begin op_a = 68'(dx); op_b = 68'(dx); end
      N_LEN2: begin op_a = 68'(dy); op_b = 68'(dy); end
      N_CR1:  begin op_a = 68'(ux); op_b = 68'(dy); end
      N_CR2:  begin op_a = 68'(uy); op_b = 68'(dx); end
      N_CSQ:  begin op_a = t[67:0]; op_b = t[67:0]; end
      N_TL:   begin op_a = $signed({4'b0, tol2}); op_b = len[67:0]; end
      N_SQ1: begin
        op_a = wsel ? 68'(vx) : 68'(ux);
        op_b = op_a;
      end
      N_SQ2: begin
        op_a = wsel ? 68'(vy) : 68'(uy);
        op_b = op_a;
      end
      default: mul_state = 1'b0;
    endcase
  end

  assign load = mul_state && !issued;
  assign take = mul_state && issued && mdone;

  // step sequencing
  always_comb begin
    nstate_next = nstate;
    fin         = 1'b0;
    fin_near    = 1'b0;
    unique case (nstate)
      N_IDLE: if (start) nstate_next = N_DOT1;
      N_DOT1: if (take) nstate_next = N_DOT2;
      N_DOT2: if (take) nstate_next = N_DCHK;
      N_DCHK: nstate_next = (dot <= 0) ? N_SQ1 : N_LEN1;
      N_LEN1: if (take) nstate_next = N_LEN2;
      N_LEN2: if (take) nstate_next = N_LCMP;
      N_LCMP: nstate_next = (dot >= len) ? N_SQ1 : N_CR1;
      N_CR1:  if (take) nstate_next = N_CR2;
      N_CR2:  if (take) nstate_next = N_CSQ;
      N_CSQ:  if (take) nstate_next = N_TL;
      N_TL: begin
        if (take) begin
          nstate_next = N_IDLE;
          fin         = 1'b1;
          fin_near    = (t <= mres);
        end
      end
      N_SQ1:  if (take) nstate_next = N_SQ2;
      N_SQ2:  if (take) nstate_next = N_DCMP;
      N_DCMP: begin
        nstate_next = N_IDLE;
        fin         = 1'b1;
        fin_near    = (t <= $signed({72'b0, tol2}));
      end
      default: nstate_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nstate <= N_IDLE;
    end else begin
      nstate <= nstate_next;
    end
  end

  // multiplier: one 16-bit digit of b per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
      mrun   <= 1'b0;
      mdone  <= 1'b0;
      mcnt   <= '0;
    end else if (load) begin
      issued <= 1'b1;
      mrun   <= 1'b1;
      mdone  <= 1'b0;
      mcnt   <= '0;
    end else begin
      if (take) issued <= 1'b0;
      if (mrun) begin
        mcnt <= mcnt + 3'd1;
        if (mcnt == 3'(MUL_STEPS - 1)) begin
          mrun  <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ma   <= mag68(op_a);
      mb   <= mag68(op_b);
      mneg <= op_a[67] ^ op_b[67];
      acc  <= '0;
    end else if (mrun) begin
      acc <= {digit_prod, 64'b0} + (acc >> 16);
      mb  <= mb >> 16;
    end
  end

  // vectors and partial sums
  always_ff @(posedge clk) begin
    if (nstate == N_IDLE && start) begin
      ux <= 33'(px) - 33'(ax);
      uy <= 33'(py) - 33'(ay);
      dx <= 33'(bx) - 33'(ax);
      dy <= 33'(by) - 33'(ay);
      vx <= 33'(px) - 33'(bx);
      vy <= 33'(py) - 33'(by);
    end
    if (nstate == N_DCHK) wsel <= 1'b0;
    if (nstate == N_LCMP) wsel <= 1'b1;
    if (take) begin
      unique case (nstate)
        N_DOT2:  dot <= t + mres;
        N_LEN2:  len <= t + mres;
        N_CR2:   t   <= t - mres;
        N_SQ2:   t   <= t + mres;
        default: t   <= mres;
      endcase
    end
  end

  // finish status, one cycle pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
      res.near <= 1'b0;
    end else begin
      res.done <= fin;
      if (fin) res.near <= fin_near;
    end
  end

endmodule

### hdl/bezier_path_flattener_unit.sv
// ----------------------------------------------------------------------------
// bezier_path_flattener_unit
// Flattens move, line, cubic curve and close segments into moves, lines and
// closes, splitting curves by adaptive De Casteljau subdivision.
// ----------------------------------------------------------------------------
// One segment is taken at a time. Move, line and close finish in the command
// state, after any wait on the output. A curve is split depth first; every
// piece below the depth limit gets one or two chord distance tests, each of
// 4, 6 or 8 multiplies on a shared 68x16 multiplier, and a curve split to full
// depth gives 32 lines out. Right halves wait in a small stack memory, one
// entry per level, read back through a registered read port in the pop state.
module bezier_path_flattener_unit (
  input  logic         clk,
  input  logic         rst,
  // input segments
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // point_a_x, point_a_y, point_b_x, point_b_y,
                                 // point_c_x, point_c_y
  input  logic [1:0]   s_tuser,  // opcode
  input  logic         s_tlast,  // path_end
  // flattened segments
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // out_x, out_y
  output logic [1:0]   m_tuser,  // out_kind
  output logic         m_tlast,  // out_last
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bpf_pkg::*;

  top_state_t state, state_next;

  logic [31:0]        flat_tolerance;
  logic [31:0]        teff;
  logic [63:0]        tol2;

  logic [1:0]         op;
  logic signed [31:0] pa_x, pa_y, pb_x, pb_y, pc_x, pc_y;
  logic               pend;

  logic signed [31:0] cur_x, cur_y, st_x, st_y;
  logic               has_pt;
  logic signed [31:0] piece [8];
  logic [LW-1:0]      level, pcount, pcount_m1;

  logic [MEM_W-1:0]   mem [MAX_LEVEL];
  logic [MEM_W-1:0]   rdata, wdata;

  logic signed [31:0] q [6];
  logic signed [31:0] r [4];
  logic signed [31:0] s [2];

  logic               can_emit, emit_go, emit_last;
  logic [1:0]         emit_kind;
  logic signed [31:0] emit_x, emit_y;
  logic               near_start, near_sel;
  near_res_t          nres;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : flat_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_tolerance <= TOL_DEFAULT;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      flat_tolerance <= pwdata;
    end
  end

  // squared tolerance
  assign teff = (flat_tolerance == 32'd0) ? TOL_DEFAULT : flat_tolerance;

  always_ff @(posedge clk) begin
    tol2 <= teff * teff;
  end

  // one subdivision at t = 0.5
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q[i]     = mid(piece[i], piece[2 + i]);
      q[2 + i] = mid(piece[2 + i], piece[4 + i]);
      q[4 + i] = mid(piece[4 + i], piece[6 + i]);
      r[i]     = mid(q[i], q[2 + i]);
      r[2 + i] = mid(q[2 + i], q[4 + i]);
      s[i]     = mid(r[i], r[2 + i]);
    end
    wdata = '0;
    for (int i = 0; i < 2; i++) begin
      wdata[32 * i +: 32]       = s[i];
      wdata[32 * (2 + i) +: 32] = r[2 + i];
      wdata[32 * (4 + i) +: 32] = q[4 + i];
      wdata[32 * (6 + i) +: 32] = piece[6 + i];
    end
    wdata[MEM_W-1 -: LW] = level + LW'(1);
  end

  // right half stack
  assign pcount_m1 = pcount - LW'(1);

  always_ff @(posedge clk) begin
    if (state == S_SPLIT) mem[pcount[SW-1:0]] <= wdata;
    rdata <= mem[pcount_m1[SW-1:0]];
  end

  // chord distance unit
  bpf_near u_near (
    .clk   (clk),
    .rst   (rst),
    .start (near_start),
    .px    (near_sel ? piece[4] : piece[2]),
    .py    (near_sel ? piece[5] : piece[3]),
    .ax    (piece[0]),
    .ay    (piece[1]),
    .bx    (piece[6]),
    .by    (piece[7]),
    .tol2  (tol2),
    .res   (nres)
  );

  assign can_emit = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // sequencing and emission
  always_comb begin
    state_next = state;
    emit_go    = 1'b0;
    emit_kind  = K_LINE;
    emit_x     = pa_x;
    emit_y     = pa_y;
    emit_last  = 1'b1;
    near_start = 1'b0;
    near_sel   = 1'b0;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_CMD;
      S_CMD: begin
        unique case (op)
          OP_MOVE: begin
            emit_kind = K_MOVE;
            if (can_emit) begin
              emit_go    = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_LINE: begin
            emit_kind = has_pt ? K_LINE : K_MOVE;
            if (can_emit) begin
              emit_go    = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_CLOSE: begin
            emit_kind = K_CLOSE;
            emit_x    = '0;
            emit_y    = '0;
            if (can_emit) begin
              emit_go    = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_CURVE: begin
            emit_kind = K_MOVE;
            emit_last = 1'b0;
            if (has_pt) begin
              state_next = S_TEST;
            end else if (can_emit) begin
              emit_go    = 1'b1;
              state_next = S_TEST;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_TEST: begin
        if (level >= LW'(MAX_LEVEL) || pcount >= LW'(MAX_LEVEL)) begin
          state_next = S_EMIT;
        end else begin
          near_start = 1'b1;
          state_next = S_NEAR1;
        end
      end
      S_NEAR1: begin
        if (nres.done) begin
          if (nres.near) begin
            near_start = 1'b1;
            near_sel   = 1'b1;
            state_next = S_NEAR2;
          end else begin
            state_next = S_SPLIT;
          end
        end
      end
      S_NEAR2: if (nres.done) state_next = nres.near ? S_EMIT : S_SPLIT;
      S_SPLIT: state_next = S_TEST;
      S_EMIT: begin
        emit_kind = K_LINE;
        emit_x    = piece[6];
        emit_y    = piece[7];
        emit_last = (pcount == '0);
        if (can_emit) begin
          emit_go    = 1'b1;
          state_next = (pcount == '0) ? S_IDLE : S_POP;
        end
      end
      S_POP: state_next = S_TEST;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      op   <= s_tuser;
      pa_x <= s_tdata[31:0];
      pa_y <= s_tdata[63:32];
      pb_x <= s_tdata[95:64];
      pb_y <= s_tdata[127:96];
      pc_x <= s_tdata[159:128];
      pc_y <= s_tdata[191:160];
      pend <= s_tlast;
    end
  end

  // current piece and stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      pcount <= '0;
    end else begin
      priority case (1'b1)
        (state == S_CMD && state_next == S_TEST): begin
          piece[0] <= has_pt ? cur_x : pa_x;
          piece[1] <= has_pt ? cur_y : pa_y;
          piece[2] <= pa_x;
          piece[3] <= pa_y;
          piece[4] <= pb_x;
          piece[5] <= pb_y;
          piece[6] <= pc_x;
          piece[7] <= pc_y;
          level    <= '0;
          pcount   <= '0;
        end
        (state == S_SPLIT): begin
          piece[2] <= q[0];
          piece[3] <= q[1];
          piece[4] <= r[0];
          piece[5] <= r[1];
          piece[6] <= s[0];
          piece[7] <= s[1];
          level    <= level + LW'(1);
          pcount   <= pcount + LW'(1);
        end
        (state == S_EMIT && emit_go && pcount != '0): pcount <= pcount_m1;
        (state == S_POP): begin
          for (int i = 0; i < 8; i++) piece[i] <= rdata[32 * i +: 32];
          level <= rdata[MEM_W-1 -: LW];
        end
        default: ;
      endcase
    end
  end

  // path position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x  <= '0;
      cur_y  <= '0;
      st_x   <= '0;
      st_y   <= '0;
      has_pt <= 1'b0;
    end else if (emit_go && emit_last && pend) begin
      cur_x  <= '0;
      cur_y  <= '0;
      st_x   <= '0;
      st_y   <= '0;
      has_pt <= 1'b0;
    end else if (state == S_CMD && state_next != S_CMD) begin
      unique case (op)
        OP_MOVE: begin
          cur_x  <= pa_x;
          cur_y  <= pa_y;
          st_x   <= pa_x;
          st_y   <= pa_y;
          has_pt <= 1'b1;
        end
        OP_LINE, OP_CURVE: begin
          if (op == OP_LINE || !has_pt) begin
            cur_x <= pa_x;
            cur_y <= pa_y;
          end
          has_pt <= 1'b1;
        end
        OP_CLOSE: begin
          cur_x <= st_x;
          cur_y <= st_y;
        end
        default: ;
      endcase
    end else if (emit_go && emit_last) begin
      cur_x <= pc_x;
      cur_y <= pc_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= {emit_y, emit_x};
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
    end
  end

endmodule

### hdl/bpf_checker.sv
// ----------------------------------------------------------------------------
// bpf_checker
// Port level checks of the flattener, bound to the top level.
// ----------------------------------------------------------------------------
module bpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import bpf_pkg::*;

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // no segment kind beyond close
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == K_MOVE || m_tuser == K_LINE || m_tuser == K_CLOSE))
    else $error("bad output kind");

  // close carries no point
  a_close: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == K_CLOSE |-> m_tdata == 64'd0)
    else $error("close with nonzero point");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

endmodule

bind bezier_path_flattener_unit bpf_checker u_bpf_checker (.*);

### verif/tb_bezier_path_flattener_unit.sv
// ----------------------------------------------------------------------------
// tb_bezier_path_flattener_unit
// Drives move, line, curve and close requests at random pace, predicts the
// flattened path with a behavioral subdivision model and checks every result.
// ----------------------------------------------------------------------------
module tb_bezier_path_flattener_unit;
  import bpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] px;
    logic [31:0] py;
    logic        last;
  } flat_seg_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;  // point_a_x, point_a_y, point_b_x, point_b_y,
                               // point_c_x, point_c_y
  logic [1:0]   s_tuser = '0;  // opcode
  logic         s_tlast = 1'b0;  // path_end
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;  // out_x, out_y
  logic [1:0]   m_tuser;  // out_kind
  logic         m_tlast;  // out_last
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  bezier_path_flattener_unit dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] tol_reg;
  logic signed [31:0] cur_x, cur_y, sub_x, sub_y;
  logic has_pt;
  flat_seg_t expected_segs[$];
  int errors = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_curves = 0;
  int rx_wait = 0;
  int rx_seen = 0;
  bit rx_hold = 1'b0;

  function automatic logic signed [31:0] half_sum(logic signed [31:0] a,
                                                  logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s >>> 1;
  endfunction

  function automatic logic [159:0] sq2(logic signed [33:0] x, logic signed [33:0] y);
    logic signed [159:0] a, b;
    a = x;
    b = y;
    return a * a + b * b;
  endfunction

  // squared distance of p to segment a-b against tol^2
  function automatic bit chord_near(logic signed [31:0] px, logic signed [31:0] py,
                                    logic signed [31:0] ax, logic signed [31:0] ay,
                                    logic signed [31:0] bx, logic signed [31:0] by,
                                    logic [159:0] tol2);
    logic signed [159:0] dx, dy, ux, uy, dot, len, cr;
    dx = 160'(bx) - 160'(ax);
    dy = 160'(by) - 160'(ay);
    ux = 160'(px) - 160'(ax);
    uy = 160'(py) - 160'(ay);
    if (dx == 0 && dy == 0) return sq2(34'(ux), 34'(uy)) <= tol2;
    dot = ux * dx + uy * dy;
    if (dot <= 0) return sq2(34'(ux), 34'(uy)) <= tol2;
    len = dx * dx + dy * dy;
    if (dot >= len) return sq2(34'(px) - 34'(bx), 34'(py) - 34'(by)) <= tol2;
    cr = ux * dy - uy * dx;
    return cr * cr <= $signed(tol2) * len;
  endfunction

  function automatic void push_seg(logic [1:0] k, logic [31:0] x, logic [31:0] y);
    flat_seg_t e;
    e.kind = k;
    e.px = x;
    e.py = y;
    e.last = 1'b0;
    expected_segs.push_back(e);
  endfunction

  // depth-first subdivision of one cubic
  function automatic void subdivide(logic signed [31:0] pts[8]);
    logic signed [31:0] c[8], q[6], r[4], s[2];
    logic signed [31:0] stack[MAX_LEVEL][8];
    int lvls[MAX_LEVEL];
    int sp, lvl;
    logic [63:0] tol;
    logic [159:0] tol2;
    bit fin;
    tol = (tol_reg == 0) ? 64'(TOL_DEFAULT) : 64'(tol_reg);
    tol2 = 160'(tol * tol);
    c = pts;
    sp = 0;
    lvl = 0;
    forever begin
      fin = lvl >= MAX_LEVEL || sp >= MAX_LEVEL ||
            (chord_near(c[2], c[3], c[0], c[1], c[6], c[7], tol2) &&
             chord_near(c[4], c[5], c[0], c[1], c[6], c[7], tol2));
      if (fin) begin
        push_seg(K_LINE, c[6], c[7]);
        if (sp == 0) break;
        sp--;
        c = stack[sp];
        lvl = lvls[sp];
        continue;
      end
      for (int i = 0; i < 2; i++) begin
        q[i] = half_sum(c[i], c[2+i]);
        q[2+i] = half_sum(c[2+i], c[4+i]);
        q[4+i] = half_sum(c[4+i], c[6+i]);
        r[i] = half_sum(q[i], q[2+i]);
        r[2+i] = half_sum(q[2+i], q[4+i]);
        s[i] = half_sum(r[i], r[2+i]);
      end
      lvl++;
      for (int i = 0; i < 2; i++) begin
        stack[sp][i] = s[i];
        stack[sp][2+i] = r[2+i];
        stack[sp][4+i] = q[4+i];
        stack[sp][6+i] = c[6+i];
      end
      lvls[sp] = lvl;
      sp++;
      for (int i = 0; i < 2; i++) begin
        c[2+i] = q[i];
        c[4+i] = r[i];
        c[6+i] = s[i];
      end
    end
  endfunction

  function automatic void predict_segment(logic [1:0] op, logic [191:0] d, bit pend);
    logic signed [31:0] pts[8];
    logic signed [31:0] ax, ay;
    ax = d[31:0];
    ay = d[63:32];
    case (op)
      OP_MOVE: begin
        push_seg(K_MOVE, ax, ay);
        cur_x = ax; cur_y = ay; sub_x = ax; sub_y = ay;
        has_pt = 1'b1;
      end
      OP_LINE: begin
        push_seg(has_pt ? K_LINE : K_MOVE, ax, ay);
        cur_x = ax; cur_y = ay;
        has_pt = 1'b1;
      end
      OP_CURVE: begin
        if (!has_pt) begin
          push_seg(K_MOVE, ax, ay);
          cur_x = ax; cur_y = ay;
          has_pt = 1'b1;
        end
        pts[0] = cur_x; pts[1] = cur_y;
        for (int i = 0; i < 6; i++) pts[2+i] = d[32*i +: 32];
        subdivide(pts);
        cur_x = d[159:128]; cur_y = d[191:160];
      end
      default: begin
        push_seg(K_CLOSE, 0, 0);
        cur_x = sub_x; cur_y = sub_y;
      end
    endcase
    expected_segs[$].last = 1'b1;
    if (pend) begin
      cur_x = 0; cur_y = 0; sub_x = 0; sub_y = 0;
      has_pt = 1'b0;
    end
  endfunction

  // send one request with a random gap before it; the flattener is busy in
  // the cycle after a request, so the gap counts from the next falling edge
  task automatic send_segment(logic [1:0] op, logic [191:0] d, bit pend);
    @(negedge clk);
    repeat ($urandom_range(0, 11)) @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    s_tlast <= pend;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_segment(op, d, pend);
    if (op == OP_CURVE) n_curves++;
    n_sent++;
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_segs.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tol_reg = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic logic [191:0] rand_points(int mode);
    logic [191:0] d;
    for (int i = 0; i < 6; i++) d[32*i +: 32] = rand_coord(mode);
    return d;
  endfunction

  // receiver stalls: a fresh random wait before each result, unless rx_hold keeps it ready
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold) begin
      m_tready <= 1'b1;
      rx_seen = n_checked;
    end else begin
      if (n_checked != rx_seen) begin
        rx_seen = n_checked;
        rx_wait = $urandom_range(0, 11);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    flat_seg_t e;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired, %0d results outstanding", $time,
                 expected_segs.size());
        $display("end of test: mismatches");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (expected_segs.size() == 0) begin
          errors++;
          $display("%0t unexpected result kind=%0d x=%h y=%h", $time, m_tuser,
                   m_tdata[31:0], m_tdata[63:32]);
        end else begin
          e = expected_segs.pop_front();
          if (m_tuser !== e.kind) begin
            errors++;
            $display("%0t kind: expected %0d actual %0d", $time, e.kind, m_tuser);
          end
          if (m_tdata[31:0] !== e.px) begin
            errors++;
            $display("%0t x: expected %h actual %h", $time, e.px, m_tdata[31:0]);
          end
          if (m_tdata[63:32] !== e.py) begin
            errors++;
            $display("%0t y: expected %h actual %h", $time, e.py, m_tdata[63:32]);
          end
          if (m_tlast !== e.last) begin
            errors++;
            $display("%0t last: expected %0d actual %0d", $time, e.last, m_tlast);
          end
        end
      end
    end
  end

  // extremes, every opcode and the no-current-point cases
  task automatic test_directed();
    send_segment(OP_CLOSE, '0, 1'b0);
    send_segment(OP_LINE, {128'd0, 32'h7fff_ffff, 32'h8000_0000}, 1'b0);
    send_segment(OP_CLOSE, '0, 1'b1);
    send_segment(OP_CURVE, {32'h0010_0000, 32'h0010_0000, 32'h0020_0000, 32'hfff0_0000,
                            32'h0005_0000, 32'h0000_0000}, 1'b0);
    send_segment(OP_MOVE, {128'd0, 32'h8000_0000, 32'h7fff_ffff}, 1'b0);
    send_segment(OP_CURVE, {32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h7fff_ffff}, 1'b0);
    send_segment(OP_CURVE, {6{32'h0001_0000}}, 1'b0);
    send_segment(OP_CURVE, {6{32'hffff_ffff}}, 1'b0);
    send_segment(OP_LINE, {128'd0, 64'h0}, 1'b0);
    send_segment(OP_CLOSE, '0, 1'b0);
    send_segment(OP_CURVE, {32'h0000_0000, 32'h0030_0000, 32'h0000_0000, 32'h0030_0000,
                            32'h0000_0000, 32'h0000_0000}, 1'b1);
    send_segment(OP_MOVE, {192{1'b1}}, 1'b0);
    send_segment(OP_LINE, {192{1'b0}}, 1'b1);
  endtask

  // sender waits for the flattener to empty before each request
  task automatic test_serialized();
    for (int i = 0; i < 12; i++) begin
      drain();
      send_segment(2'($urandom_range(0, 3)), rand_points($urandom_range(0, 2)),
                   $urandom_range(0, 3) == 0);
    end
  endtask

  // well-formed paths with random content, plus some loose requests
  task automatic test_random_paths(int n_items);
    int cnt, plen, mode;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_segment(2'($urandom_range(0, 3)), rand_points(0), $urandom_range(0, 1));
        cnt++;
      end else begin
        mode = $urandom_range(0, 2);
        plen = $urandom_range(2, 7);
        send_segment(OP_MOVE, rand_points(mode), 1'b0);
        for (int j = 0; j < plen; j++)
          send_segment(($urandom_range(0, 2) == 0) ? OP_LINE : OP_CURVE,
                       rand_points(mode), 1'b0);
        send_segment(OP_CLOSE, rand_points(mode), $urandom_range(0, 1));
        cnt += plen + 2;
      end
    end
  endtask

  // a stretch with no receiver stalls
  task automatic test_no_stall();
    rx_hold = 1'b1;
    for (int i = 0; i < 15; i++)
      send_segment(2'($urandom_range(0, 3)), rand_points(1), $urandom_range(0, 4) == 0);
    drain();
    rx_hold = 1'b0;
  endtask

  initial begin
    tol_reg = TOL_DEFAULT;
    cur_x = 0; cur_y = 0; sub_x = 0; sub_y = 0;
    has_pt = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    drain();
    write_tolerance(32'd0);
    test_directed();
    test_serialized();
    drain();
    write_tolerance(32'hffff_ffff);
    test_random_paths(50);
    drain();
    write_tolerance(32'd1);
    test_random_paths(90);
    drain();
    write_tolerance(32'h0000_0400);
    test_random_paths(130);
    test_no_stall();
    write_tolerance(32'h0001_0000);
    test_random_paths(130);
    drain();

    $display("covered %0d requests (%0d curves), %0d results checked", n_sent, n_curves,
             n_checked);
    $display("tolerance settings zero, one, small, default, one unit and maximum");
    if (errors == 0 && expected_segs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/bpf_pkg.sv
hdl/bpf_near.sv
hdl/bezier_path_flattener_unit.sv
hdl/bpf_checker.sv
verif/tb_bezier_path_flattener_unit.sv
